FILE: rtl/ecdt_pkg.sv
package ecdt_pkg;

   // port widths
   localparam int ReqDataW = 40;
   localparam int RspDataW = 48;

   // pipeline depth
   localparam int Stages = 14;

   // seconds of a day and the bias that makes every count non-negative
   localparam logic [16:0] SecsPerDay  = 17'd86400;
   localparam int          DayBias     = 6362915;
   localparam logic [40:0] DayBiasSecs = 41'(64'(DayBias) * 64'd86400);

   // floor reciprocal of a day, applied to the count with its low 17 bits dropped
   localparam logic [24:0] DayRecip = 25'((64'd1 << 41) / 64'd86400);

   // day count origin moved to march 1st of year 0, plus whole eras to stay non-negative
   localparam int          EpochShift = 719468;
   localparam int          EraBias    = 39;
   localparam logic [17:0] DaysPerEra = 18'd146097;
   localparam logic [23:0] ZBias      = 24'(EpochShift + EraBias * 146097 - DayBias);
   localparam logic [6:0]  EraRecip   = 7'((64'd1 << 24) / 64'd146097);

   // time of day
   localparam logic [11:0] SecsPerHour = 12'd3600;
   localparam logic [15:0] HourRecip   = 16'(((64'd1 << 27) + 64'd3599) / 64'd3600);
   localparam logic [5:0]  SecsPerMin  = 6'd60;
   localparam logic [12:0] MinRecip    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

   // year of era
   localparam logic [10:0] DaysPer4Y   = 11'd1460;
   localparam logic [7:0]  Recip4Y     = 8'((64'd1 << 18) / 64'd1460);
   localparam logic [15:0] DaysPerCent = 16'd36524;
   localparam logic [17:0] DaysEraLast = 18'd146096;
   localparam logic [8:0]  DaysPerYear = 9'd365;
   localparam logic [9:0]  YearRecip   = 10'((64'd1 << 18) / 64'd365);
   localparam logic [8:0]  YearsCent   = 9'd100;
   localparam logic [15:0] EraYears    = 16'd400;
   localparam logic [15:0] YearBias    = 16'(EraBias * 400);

   // march-based month numbers
   localparam logic [3:0] MonthsMar = 4'd10;
   localparam logic [3:0] MarchNum  = 4'd3;
   localparam logic [3:0] JanShift  = 4'd9;
   localparam logic [3:0] FebNum    = 4'd2;

   // payload carried down the pipeline
   typedef struct packed {
      logic [40:0] u;
      logic [23:0] qe;
      logic [19:0] m20;
      logic [16:0] sod;
      logic [23:0] z;
      logic [6:0]  era;
      logic [19:0] ep;
      logic [17:0] doe;
      logic [11:0] rs;
      logic [6:0]  c1460;
      logic [2:0]  c36524;
      logic        cfull;
      logic [17:0] n;
      logic [8:0]  yoe;
      logic [8:0]  doy;
      logic [3:0]  mp;
      logic [15:0] ybase;
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } pipe_type;

   // first day of each month in a march-based year
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start;
      unique case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

FILE: rtl/epoch_to_civil_datetime_core.sv
// each input transfer is registered through every pipeline stage before its result shows on rsp_tdata
// throughput: one conversion per cycle; a stage takes a new item while the output
// drains or while it or any stage after it is empty
// each stage keeps to a short multiply, compare or add chain on any path
// reset clears the stage valid bits only; data registers are not reset
module epoch_to_civil_datetime_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ecdt_pkg::ReqDataW-1:0]  req_tdata,   // [39:0] epoch_seconds
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] year, [19:16] month, [24:20] day, [29:25] hour,
   // [35:30] minute, [41:36] second, [47:42] zero
   output logic [ecdt_pkg::RspDataW-1:0]  rsp_tdata
);

   localparam int Last = ecdt_pkg::Stages - 1;

   localparam logic [19:0] Day1 = 20'(ecdt_pkg::SecsPerDay);
   localparam logic [19:0] Day2 = 20'(2 * 86400);
   localparam logic [19:0] Day3 = 20'(3 * 86400);

   logic [ecdt_pkg::Stages-1:0] valid_ff;
   logic [ecdt_pkg::Stages-1:0] valid_in;
   logic [ecdt_pkg::Stages-1:0] stage_ready;
   ecdt_pkg::pipe_type          stage_ff [ecdt_pkg::Stages];
   ecdt_pkg::pipe_type          stage_in [ecdt_pkg::Stages];

   // a stage can load when the output drains or any stage from it down is empty
   for (genvar i = 0; i < ecdt_pkg::Stages; i++) begin : g_ready
      assign stage_ready[i] = rsp_tready || !(&valid_ff[Last:i]);
   end

   assign req_tready = stage_ready[0];

   // valid bits move with the data
   always_comb begin
      valid_in[0] = stage_ready[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < ecdt_pkg::Stages; i++) begin
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ecdt_pkg::Stages; i++) begin
         if (stage_ready[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // stage logic
   always_comb begin
      logic [48:0] day_prod;
      logic [40:0] day_back;
      logic [19:0] rem20;
      logic [23:0] zsum;
      logic [30:0] era_prod;
      logic [32:0] hour_prod;
      logic [24:0] era_back;
      logic [16:0] hour_back;
      logic [19:0] doe_est;
      logic [24:0] min_prod;
      logic [25:0] q4y_prod;
      logic [11:0] min_back;
      logic [17:0] back4y;
      logic [11:0] rem4y;
      logic [6:0]  c4y;
      logic [27:0] year_prod;
      logic [17:0] back365;
      logic [9:0]  rem365;
      logic [1:0]  cent;
      logic [17:0] ystart;
      logic [11:1] ge_month;
      logic [8:0]  mstart;
      logic [3:0]  mon;

      // bias the count so floored division becomes plain division
      stage_in[0]   = '0;
      stage_in[0].u = {req_tdata[39], req_tdata} + ecdt_pkg::DayBiasSecs;

      // day estimate from the upper bits, never above the true day
      stage_in[1]    = stage_ff[0];
      day_prod       = 49'(stage_ff[0].u[40:17]) * 49'(ecdt_pkg::DayRecip);
      stage_in[1].qe = day_prod[47:24];

      // seconds covered by the estimate, low bits are enough
      stage_in[2]     = stage_ff[1];
      day_back        = 41'(stage_ff[1].qe) * 41'(ecdt_pkg::SecsPerDay);
      stage_in[2].m20 = day_back[19:0];

      // estimate is short by at most three days
      stage_in[3] = stage_ff[2];
      rem20       = stage_ff[2].u[19:0] - stage_ff[2].m20;
      priority if (rem20 >= Day3) begin
         stage_in[3].qe  = stage_ff[2].qe + 24'd3;
         stage_in[3].sod = 17'(rem20 - Day3);
      end else if (rem20 >= Day2) begin
         stage_in[3].qe  = stage_ff[2].qe + 24'd2;
         stage_in[3].sod = 17'(rem20 - Day2);
      end else if (rem20 >= Day1) begin
         stage_in[3].qe  = stage_ff[2].qe + 24'd1;
         stage_in[3].sod = 17'(rem20 - Day1);
      end else begin
         stage_in[3].sod = 17'(rem20);
      end

      // shifted day count, era estimate and hour
      stage_in[4]      = stage_ff[3];
      zsum             = stage_ff[3].qe + ecdt_pkg::ZBias;
      era_prod         = 31'(zsum) * 31'(ecdt_pkg::EraRecip);
      hour_prod        = 33'(stage_ff[3].sod) * 33'(ecdt_pkg::HourRecip);
      stage_in[4].z    = zsum;
      stage_in[4].era  = era_prod[30:24];
      stage_in[4].hour = hour_prod[31:27];

      // days covered by the era estimate, seconds left in the hour
      stage_in[5]    = stage_ff[4];
      era_back       = 25'(stage_ff[4].era) * 25'(ecdt_pkg::DaysPerEra);
      hour_back      = 17'(stage_ff[4].hour) * 17'(ecdt_pkg::SecsPerHour);
      stage_in[5].ep = era_back[19:0];
      stage_in[5].rs = 12'(stage_ff[4].sod - hour_back);

      // era estimate is short by at most one; minute
      stage_in[6] = stage_ff[5];
      doe_est     = stage_ff[5].z[19:0] - stage_ff[5].ep;
      if (doe_est >= 20'(ecdt_pkg::DaysPerEra)) begin
         stage_in[6].doe = 18'(doe_est - 20'(ecdt_pkg::DaysPerEra));
         stage_in[6].era = stage_ff[5].era + 7'd1;
      end else begin
         stage_in[6].doe = 18'(doe_est);
      end
      min_prod           = 25'(stage_ff[5].rs) * 25'(ecdt_pkg::MinRecip);
      stage_in[6].minute = min_prod[23:18];

      // leap corrections of the day of era, second
      stage_in[7]        = stage_ff[6];
      q4y_prod           = 26'(stage_ff[6].doe) * 26'(ecdt_pkg::Recip4Y);
      stage_in[7].c1460  = q4y_prod[24:18];
      stage_in[7].c36524 = 3'(stage_ff[6].doe >= 18'(ecdt_pkg::DaysPerCent))
                         + 3'(stage_ff[6].doe >= 18'(2 * 36524))
                         + 3'(stage_ff[6].doe >= 18'(3 * 36524))
                         + 3'(stage_ff[6].doe >= ecdt_pkg::DaysEraLast);
      stage_in[7].cfull  = (stage_ff[6].doe == ecdt_pkg::DaysEraLast);
      min_back           = 12'(stage_ff[6].minute) * 12'(ecdt_pkg::SecsPerMin);
      stage_in[7].second = 6'(stage_ff[6].rs - min_back);

      // finish the four-year count and fold the corrections in
      stage_in[8] = stage_ff[7];
      back4y      = 18'(stage_ff[7].c1460) * 18'(ecdt_pkg::DaysPer4Y);
      rem4y       = 12'(stage_ff[7].doe - back4y);
      c4y         = stage_ff[7].c1460 + 7'(rem4y >= 12'(ecdt_pkg::DaysPer4Y));
      stage_in[8].c1460 = c4y;
      stage_in[8].n     = stage_ff[7].doe - 18'(c4y) + 18'(stage_ff[7].c36524)
                        - 18'(stage_ff[7].cfull);

      // year of era estimate
      stage_in[9]     = stage_ff[8];
      year_prod       = 28'(stage_ff[8].n) * 28'(ecdt_pkg::YearRecip);
      stage_in[9].yoe = year_prod[26:18];

      // year estimate is short by at most one
      stage_in[10]     = stage_ff[9];
      back365          = 18'(stage_ff[9].yoe) * 18'(ecdt_pkg::DaysPerYear);
      rem365           = 10'(stage_ff[9].n - back365);
      stage_in[10].yoe = stage_ff[9].yoe + 9'(rem365 >= 10'(ecdt_pkg::DaysPerYear));

      // day of the march-based year
      stage_in[11] = stage_ff[10];
      cent = 2'(stage_ff[10].yoe >= ecdt_pkg::YearsCent)
           + 2'(stage_ff[10].yoe >= 9'(2 * 100))
           + 2'(stage_ff[10].yoe >= 9'(3 * 100));
      ystart = 18'(stage_ff[10].yoe) * 18'(ecdt_pkg::DaysPerYear)
             + 18'(stage_ff[10].yoe[8:2]) - 18'(cent);
      stage_in[11].doy = 9'(stage_ff[10].doe - ystart);

      // month number from the month start table, year before the jan/feb carry
      stage_in[12] = stage_ff[11];
      for (int i = 1; i < 12; i++) begin
         ge_month[i] = (stage_ff[11].doy >= ecdt_pkg::month_start(4'(i)));
      end
      stage_in[12].mp    = 4'($countones(ge_month));
      stage_in[12].ybase = 16'(stage_ff[11].yoe)
                         + 16'(stage_ff[11].era) * ecdt_pkg::EraYears;

      // final fields
      stage_in[13] = stage_ff[12];
      mstart       = ecdt_pkg::month_start(stage_ff[12].mp);
      if (stage_ff[12].mp < ecdt_pkg::MonthsMar) begin
         mon = stage_ff[12].mp + ecdt_pkg::MarchNum;
      end else begin
         mon = stage_ff[12].mp - ecdt_pkg::JanShift;
      end
      stage_in[13].month = mon;
      stage_in[13].day   = 5'(stage_ff[12].doy - mstart + 9'd1);
      stage_in[13].year  = stage_ff[12].ybase - ecdt_pkg::YearBias
                         + 16'(mon <= ecdt_pkg::FebNum);
   end

   // result channel
   assign rsp_tvalid = valid_ff[Last];
   assign rsp_tdata  = {6'd0,
                        stage_ff[Last].second,
                        stage_ff[Last].minute,
                        stage_ff[Last].hour,
                        stage_ff[Last].day,
                        stage_ff[Last].month,
                        stage_ff[Last].year};

`ifndef SYNTHESIS
   // corrected seconds of day stay inside one day
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (stage_ff[3].sod < ecdt_pkg::SecsPerDay))
      else $error("seconds of day out of range after correction");

   // corrected day of era stays inside one era
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> (stage_ff[6].doe < ecdt_pkg::DaysPerEra))
      else $error("day of era out of range after correction");

   // year of era fits an era and day of year fits a march-based year
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[11] |-> (stage_ff[11].yoe < 9'd400 && stage_ff[11].doy < 9'd366))
      else $error("year of era or day of year out of range");

   // month of a result is in range and its day is at least one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (stage_ff[Last].month >= 4'd1 && stage_ff[Last].month <= 4'd12
                      && stage_ff[Last].day >= 5'd1))
      else $error("month or day out of range");

   // time fields of a result are in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (stage_ff[Last].hour <= 5'd23 && stage_ff[Last].minute <= 6'd59
                      && stage_ff[Last].second <= 6'd59))
      else $error("time of day out of range");
`endif

endmodule

FILE: tb/epoch_to_civil_datetime_core_test.sv
`timescale 1ns / 1ps

module epoch_to_civil_datetime_core_test;

   localparam longint DaySecs     = 86400;
   localparam longint MarchShift  = 719468;
   localparam longint EraDays     = 146097;
   localparam int     CycleLimit  = 400000;
   localparam int     ReportLimit = 10;

   // receiver stall patterns
   typedef enum logic [1:0] {
      StallNone,
      StallRandom,
      StallPattern,
      StallHeavy
   } stall_mode_type;

   // one result transfer, packed as on rsp_tdata (year in the lowest bits)
   typedef struct packed {
      logic [5:0]         pad;
      logic [5:0]         second;
      logic [5:0]         minute;
      logic [4:0]         hour;
      logic [4:0]         day;
      logic [3:0]         month;
      logic signed [15:0] year;
   } civil_date_type;

   typedef struct {
      logic [39:0]    stamp;
      civil_date_type date;
   } pending_date_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [ecdt_pkg::ReqDataW-1:0] req_tdata  = '0;   // [39:0] epoch_seconds
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // [15:0] year, [19:16] month, [24:20] day, [29:25] hour,
   // [35:30] minute, [41:36] second, [47:42] zero
   logic [ecdt_pkg::RspDataW-1:0] rsp_tdata;

   pending_date_type pending_dates [$];
   int               mismatch_count = 0;
   int               run_cycles     = 0;
   int unsigned      stall_tick     = 0;
   stall_mode_type   stall_mode     = StallNone;
   int unsigned      gap_max        = 0;
   int unsigned      burst_max      = 1;
   int unsigned      burst_left     = 0;

   epoch_to_civil_datetime_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // calendar date and time of day for a 40-bit signed second count
   function automatic civil_date_type civil_from_epoch(input logic [39:0] stamp);
      longint         secs, days, sod, z, era, doe, yoe, doy, mp, mon, yr, dom;
      civil_date_type c;
      secs = {{24{stamp[39]}}, stamp};
      days = secs / DaySecs;
      sod  = secs % DaySecs;
      // floored split: a negative remainder borrows a day
      if (sod < 0) begin
         sod  = sod + DaySecs;
         days = days - 1;
      end
      // march 1st of year 0 as origin, then 400-year eras
      z    = days + MarchShift;
      era  = (z >= 0 ? z : z - (EraDays - 1)) / EraDays;
      doe  = z - era * EraDays;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      dom  = doy - (153 * mp + 2) / 5 + 1;
      yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
      c.pad    = '0;
      c.year   = yr[15:0];
      c.month  = mon[3:0];
      c.day    = dom[4:0];
      c.hour   = 5'(sod / 3600);
      c.minute = 6'((sod % 3600) / 60);
      c.second = 6'(sod % 60);
      return c;
   endfunction

   function automatic logic [39:0] at_day(input longint days, input longint sod);
      longint secs;
      secs = days * DaySecs + sod;
      return secs[39:0];
   endfunction

   // second of day biased toward hour, minute and day edges
   function automatic longint pick_sod();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return DaySecs - 1;
         2:       return 3599;
         3:       return 3600;
         4:       return 59;
         5:       return 60;
         6:       return 43199;
         default: return longint'($urandom_range(0, 86399));
      endcase
   endfunction

   task automatic set_traffic(input int unsigned gaps, input int unsigned bursts,
                              input stall_mode_type stalls);
      gap_max    = gaps;
      burst_max  = bursts;
      burst_left = 0;
      stall_mode = stalls;
   endtask

   // one input transfer, with a random gap once the current burst runs out
   task automatic send_stamp(input logic [39:0] stamp);
      int unsigned gap;
      if (gap_max != 0 && burst_left == 0) begin
         gap        = $urandom_range(1, gap_max);
         burst_left = $urandom_range(1, burst_max);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left != 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
   endtask

   // extremes, sign changes and calendar corner dates
   task automatic test_directed();
      set_traffic(0, 1, StallNone);
      send_stamp(40'd0);
      send_stamp(40'd1);
      send_stamp(at_day(-1, 86399));
      send_stamp(at_day(0, 86399));
      send_stamp(at_day(1, 0));
      send_stamp(at_day(-1, 0));
      send_stamp(at_day(-2, 86399));
      send_stamp(40'h7F_FFFF_FFFF);
      send_stamp(40'h80_0000_0000);
      send_stamp(40'h55_5555_5555);
      send_stamp(40'hAA_AAAA_AAAA);
      send_stamp(at_day(24855, 11647));
      send_stamp(at_day(24855, 11648));
      send_stamp(at_day(49710, 23295));
      // century turn and leap day of a 400-year leap
      send_stamp(at_day(10956, 86399));
      send_stamp(at_day(10957, 0));
      send_stamp(at_day(11016, 0));
      send_stamp(at_day(11016, 86399));
      // 1900 has no leap day
      send_stamp(at_day(-25509, 86399));
      send_stamp(at_day(-25508, 0));
      // era boundaries around march 1st of year 0 and of year -400
      send_stamp(at_day(-MarchShift, 0));
      send_stamp(at_day(-MarchShift - 1, 86399));
      send_stamp(at_day(-MarchShift - EraDays, 0));
      send_stamp(at_day(-MarchShift - EraDays - 1, 86399));
      send_stamp(at_day(157113, 45296));
   endtask

   // any 40-bit count, about half of them narrowed to a random signed width
   task automatic test_full_range();
      logic [63:0] raw;
      logic [39:0] stamp;
      int unsigned w;
      for (int i = 0; i < 450; i++) begin
         if (i == 0)   set_traffic(0, 1, StallNone);
         if (i == 100) set_traffic(4, 8, StallRandom);
         if (i == 250) set_traffic(12, 3, StallPattern);
         raw   = {$urandom(), $urandom()};
         stamp = raw[39:0];
         if ($urandom_range(0, 1) == 1) begin
            w = $urandom_range(1, 39);
            for (int b = w; b < 40; b++) stamp[b] = stamp[w - 1];
         end
         send_stamp(stamp);
      end
   endtask

   // dates within 100000 days of the epoch with edge times of day
   task automatic test_day_edges();
      longint days;
      set_traffic(2, 20, StallHeavy);
      for (int i = 0; i < 300; i++) begin
         if (i == 150) set_traffic(6, 2, StallRandom);
         days = longint'($urandom_range(0, 200000)) - 100000;
         send_stamp(at_day(days, pick_sod()));
      end
   endtask

   // year, century and era edges over the whole span of the input
   task automatic test_calendar_edges();
      longint era, yoe, doy, doe, days;
      set_traffic(3, 6, StallPattern);
      for (int i = 0; i < 280; i++) begin
         if (i == 140) set_traffic(0, 1, StallRandom);
         era = longint'($urandom_range(0, 85)) - 38;
         yoe = longint'($urandom_range(0, 399));
         case ($urandom_range(0, 7))
            0:       doy = 0;
            1:       doy = 305;
            2:       doy = 306;
            3:       doy = 337;
            4:       doy = 364;
            5:       doy = 365;
            default: doy = longint'($urandom_range(0, 365));
         endcase
         doe = 365 * yoe + yoe / 4 - yoe / 100 + doy;
         case ($urandom_range(0, 9))
            0:       doe = 0;
            1:       doe = 36524;
            2:       doe = 36525;
            3:       doe = EraDays - 1;
            default: ;
         endcase
         if (doe > EraDays - 1) doe = EraDays - 1;
         days = era * EraDays + doe - MarchShift + longint'($urandom_range(0, 2)) - 1;
         send_stamp(at_day(days, pick_sod()));
      end
   endtask

   task automatic note_mismatch(input string what, input logic [39:0] stamp,
                                input civil_date_type want, input civil_date_type got);
      if (mismatch_count < ReportLimit)
         $display({"%s: stamp %0d expected %0d-%0d-%0d %0d:%0d:%0d pad %0d,",
                   " got %0d-%0d-%0d %0d:%0d:%0d pad %0d"},
                  what, $signed(stamp),
                  want.year, want.month, want.day, want.hour, want.minute, want.second,
                  want.pad,
                  got.year, got.month, got.day, got.hour, got.minute, got.second, got.pad);
      mismatch_count++;
   endtask

   // receiver ready pattern
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         StallNone:    rsp_tready <= 1'b1;
         StallRandom:  rsp_tready <= ($urandom_range(0, 3) != 0);
         StallPattern: rsp_tready <= ((stall_tick % 11) < 6);
         StallHeavy:   rsp_tready <= ($urandom_range(0, 4) == 0);
         default:      rsp_tready <= 1'b1;
      endcase
   end

   // queue expected dates on input transfers, check each result transfer
   always @(posedge clock) begin
      pending_date_type head;
      civil_date_type   got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_dates.push_back('{stamp: req_tdata, date: civil_from_epoch(req_tdata)});
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_dates.size() == 0) begin
               note_mismatch("unexpected result", '0, '0, got);
            end else begin
               head = pending_dates.pop_front();
               if (got !== head.date)
                  note_mismatch("mismatch", head.stamp, head.date, got);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles > CycleLimit) begin
         $display("epoch_to_civil_datetime_core_test: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_range();
      test_day_edges();
      test_calendar_edges();
      req_tvalid <= 1'b0;
      stall_mode = StallRandom;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (ecdt_pkg::Stages + 6) @(posedge clock);
      if (mismatch_count == 0)
         $display("epoch_to_civil_datetime_core_test: done, clean");
      else
         $display("epoch_to_civil_datetime_core_test: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/ecdt_pkg.sv
rtl/epoch_to_civil_datetime_core.sv
tb/epoch_to_civil_datetime_core_test.sv
